### sv/process_queue_table_macros.svh
// Assertion macros used by the checker file.
`ifndef PROCESS_QUEUE_TABLE_MACROS_SVH
`define PROCESS_QUEUE_TABLE_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define PQT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define PQT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/pqt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqt_pkg
// Shared types and constants for the process queue table.
// ----------------------------------------------------------------------------
package pqt_pkg;

  localparam int Depth      = 32;
  localparam int HandleBits = 8;
  localparam int IdxW       = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW       = $clog2(Depth + 1);
  localparam int NumQueues  = 4;

  typedef logic [IdxW-1:0]       idx_t;
  typedef logic [CntW-1:0]       cnt_t;
  typedef logic [HandleBits-1:0] hnd_t;

  localparam logic [2:0] OpAppend = 3'd0;
  localparam logic [2:0] OpPrio   = 3'd1;
  localparam logic [2:0] OpRmHead = 3'd2;
  localparam logic [2:0] OpRmHnd  = 3'd3;
  localparam logic [2:0] OpLocate = 3'd4;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  // One entry of the shared store.
  typedef struct packed {
    hnd_t       handle;
    logic [7:0] prio;
    idx_t       link;
  } entry_t;

  // Write request from the sequencer to the store.
  typedef struct packed {
    logic   we;
    idx_t   addr;
    entry_t data;
  } mem_wr_t;

endpackage

### sv/pqt_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqt_store
// Entry memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pqt_store (
  input  logic             clk,
  input  pqt_pkg::mem_wr_t wr,
  input  pqt_pkg::idx_t    rd_addr,
  output pqt_pkg::entry_t  rd_data
);

  pqt_pkg::entry_t mem [pqt_pkg::Depth];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/pqt_free_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqt_free_scan
// Occupancy flags per slot and the lowest free slot search.
// ----------------------------------------------------------------------------
module pqt_free_scan (
  input  logic          clk,
  input  logic          rst,
  input  logic          set_en,
  input  pqt_pkg::idx_t set_idx,
  input  logic          clr_en,
  input  pqt_pkg::idx_t clr_idx,
  output logic          full,
  output pqt_pkg::idx_t free_idx
);

  logic [pqt_pkg::Depth-1:0] in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else begin
      if (set_en) in_use[set_idx] <= 1'b1;
      if (clr_en) in_use[clr_idx] <= 1'b0;
    end
  end

  // Priority encoder over the occupancy flags, lowest index wins.
  always_comb begin
    full     = 1'b1;
    free_idx = '0;
    for (int i = pqt_pkg::Depth - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        full     = 1'b0;
        free_idx = pqt_pkg::IdxW'(i);
      end
    end
  end

endmodule

### sv/process_queue_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// process_queue_table
// Four linked process queues in one shared entry store, walked one link
// per step by a small sequencer.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake        Word
// command   in         start, busy      opcode, queue_sel, proc_handle, proc_priority
// result    out        done (strobe)    status, out_handle, out_priority, location,
//                                       queue_length
//
// Full store, empty queue and unused codes go straight to S_FINISH; an append to
// an empty queue passes S_LINK, remove head S_READ and S_CHECK, and an append
// behind a tail S_READ, S_CHECK, S_LINK and S_PATCH. Priority insert, remove by
// handle and locate pass S_READ and S_CHECK for every visited entry, set by the
// single store read port and its registered output; the longest word is a locate
// over a full store. The result strobe comes in the first idle cycle, when the next
// word may already be accepted. Reset clears occupancy flags and queue registers.
// ----------------------------------------------------------------------------
module process_queue_table (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          opcode,
  input  logic [1:0]          queue_sel,
  input  logic [7:0]          proc_handle,
  input  logic signed [7:0]   proc_priority,
  output logic                done,
  output logic [1:0]          status,
  output logic [7:0]          out_handle,
  output logic signed [7:0]   out_priority,
  output logic [2:0]          location,
  output logic [5:0]          queue_length
);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CHECK, S_LINK, S_PATCH, S_FINISH
  } state_t;

  state_t state, state_next;

  pqt_pkg::idx_t head [pqt_pkg::NumQueues];
  pqt_pkg::idx_t tail [pqt_pkg::NumQueues];
  pqt_pkg::cnt_t count [pqt_pkg::NumQueues];
  pqt_pkg::idx_t head_next [pqt_pkg::NumQueues];
  pqt_pkg::idx_t tail_next [pqt_pkg::NumQueues];
  pqt_pkg::cnt_t count_next [pqt_pkg::NumQueues];

  logic [2:0]          op, op_next;
  logic [1:0]          qsel, qsel_next;
  logic [1:0]          wq, wq_next;       // queue being walked
  pqt_pkg::hnd_t       hnd, hnd_next;
  logic [7:0]          prio, prio_next;
  pqt_pkg::idx_t       cur, cur_next, prev, prev_next, newi, newi_next;
  pqt_pkg::entry_t     prev_ent, prev_ent_next;
  logic                has_prev, has_prev_next;
  pqt_pkg::cnt_t       k, k_next;
  logic [1:0]          status_next;
  logic [7:0]          out_handle_next;
  logic [7:0]          out_priority_next;
  logic [2:0]          location_next;

  pqt_pkg::mem_wr_t    wr;
  pqt_pkg::idx_t       rd_addr;
  pqt_pkg::entry_t     rd_data;

  logic                set_en, clr_en, full;
  pqt_pkg::idx_t       clr_idx, free_idx;

  pqt_store u_store (.clk, .wr, .rd_addr, .rd_data);

  pqt_free_scan u_free (
    .clk, .rst, .set_en, .set_idx(free_idx), .clr_en, .clr_idx,
    .full, .free_idx
  );

  assign busy = (state != S_IDLE);

  // Read address: the entry at cur in every walking state.
  assign rd_addr = cur;

  always_comb begin
    state_next        = state;
    op_next           = op;
    qsel_next         = qsel;
    wq_next           = wq;
    hnd_next          = hnd;
    prio_next         = prio;
    cur_next          = cur;
    prev_next         = prev;
    newi_next         = newi;
    prev_ent_next     = prev_ent;
    has_prev_next     = has_prev;
    k_next            = k;
    head_next         = head;
    tail_next         = tail;
    count_next        = count;
    status_next       = status;
    out_handle_next   = out_handle;
    out_priority_next = out_priority;
    location_next     = location;
    wr                = '0;
    set_en            = 1'b0;
    clr_en            = 1'b0;
    clr_idx           = cur;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_next           = opcode;
          qsel_next         = queue_sel;
          wq_next           = queue_sel;
          hnd_next          = proc_handle[pqt_pkg::HandleBits-1:0];
          prio_next         = proc_priority;
          cur_next          = head[queue_sel];
          prev_next         = '0;
          has_prev_next     = 1'b0;
          k_next            = '0;
          status_next       = pqt_pkg::StOk;
          out_handle_next   = '0;
          out_priority_next = '0;
          location_next     = '0;
          state_next        = S_FINISH;
          unique case (opcode)
            pqt_pkg::OpAppend, pqt_pkg::OpPrio: begin
              if (full) begin
                status_next = pqt_pkg::StFull;
              end else begin
                newi_next = free_idx;
                set_en    = 1'b1;
                if (opcode == pqt_pkg::OpPrio) begin
                  state_next = S_READ;
                end else begin
                  // An append reads the tail first so its link can be patched.
                  k_next     = count[queue_sel];
                  cur_next   = tail[queue_sel];
                  state_next = (count[queue_sel] == '0) ? S_LINK : S_READ;
                end
              end
            end
            pqt_pkg::OpRmHead, pqt_pkg::OpRmHnd: begin
              if (count[queue_sel] == '0) begin
                status_next = pqt_pkg::StEmpty;
              end else begin
                state_next = S_READ;
              end
            end
            pqt_pkg::OpLocate: begin
              wq_next    = 2'd0;
              cur_next   = head[0];
              state_next = S_READ;
            end
            default: begin
              state_next = S_FINISH;
            end
          endcase
        end
      end
      S_READ: begin
        // Store output is valid in the next cycle.
        priority if (op == pqt_pkg::OpLocate && k == count[wq]) begin
          if (wq == 2'd3) begin
            state_next = S_FINISH;
          end else begin
            wq_next  = wq + 2'd1;
            cur_next = head[wq + 2'd1];
            k_next   = '0;
          end
        end else if (op == pqt_pkg::OpPrio && k == count[qsel]) begin
          state_next = S_LINK;
        end else if (op == pqt_pkg::OpRmHnd && k == count[qsel]) begin
          status_next = pqt_pkg::StEmpty;
          state_next  = S_FINISH;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        unique case (op)
          pqt_pkg::OpAppend: begin
            prev_next     = cur;
            prev_ent_next = rd_data;
            has_prev_next = 1'b1;
            state_next    = S_LINK;
          end
          pqt_pkg::OpPrio: begin
            if ($signed(rd_data.prio) <= $signed(prio)) begin
              state_next = S_LINK;
            end else begin
              prev_next     = cur;
              prev_ent_next = rd_data;
              has_prev_next = 1'b1;
              cur_next      = rd_data.link;
              k_next        = k + pqt_pkg::CntW'(1);
              state_next    = S_READ;
            end
          end
          pqt_pkg::OpLocate: begin
            if (rd_data.handle == hnd) begin
              location_next = {1'b0, wq} + 3'd1;
              state_next    = S_FINISH;
            end else begin
              cur_next   = rd_data.link;
              k_next     = k + pqt_pkg::CntW'(1);
              state_next = S_READ;
            end
          end
          default: begin
            // Remove head or remove by handle.
            if (op == pqt_pkg::OpRmHead || rd_data.handle == hnd) begin
              out_handle_next   = 8'(rd_data.handle);
              out_priority_next = rd_data.prio;
              clr_en            = 1'b1;
              count_next[qsel]  = count[qsel] - pqt_pkg::CntW'(1);
              if (count[qsel] == pqt_pkg::CntW'(1)) begin
                head_next[qsel] = '0;
                tail_next[qsel] = '0;
              end else begin
                if (!has_prev) head_next[qsel] = rd_data.link;
                if (k + pqt_pkg::CntW'(1) == count[qsel]) tail_next[qsel] = prev;
              end
              // The predecessor was captured on the way, so it is rewritten here.
              if (has_prev) begin
                wr.we   = 1'b1;
                wr.addr = prev;
                wr.data = '{handle: prev_ent.handle, prio: prev_ent.prio,
                            link: rd_data.link};
              end
              state_next = S_FINISH;
            end else begin
              prev_next     = cur;
              prev_ent_next = rd_data;
              has_prev_next = 1'b1;
              cur_next      = rd_data.link;
              k_next        = k + pqt_pkg::CntW'(1);
              state_next    = S_READ;
            end
          end
        endcase
      end
      S_LINK: begin
        // Write the new entry; the predecessor is patched in the next cycle.
        wr.we   = 1'b1;
        wr.addr = newi;
        wr.data = '{handle: hnd, prio: prio,
                    link: (k == count[qsel]) ? '0 : cur};
        count_next[qsel] = count[qsel] + pqt_pkg::CntW'(1);
        if (!has_prev) head_next[qsel] = newi;
        if (k == count[qsel]) tail_next[qsel] = newi;
        state_next = has_prev ? S_PATCH : S_FINISH;
      end
      S_PATCH: begin
        wr.we      = 1'b1;
        wr.addr    = prev;
        wr.data    = '{handle: prev_ent.handle, prio: prev_ent.prio, link: newi};
        state_next = S_FINISH;
      end
      S_FINISH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      for (int i = 0; i < pqt_pkg::NumQueues; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      state <= state_next;
      done  <= (state == S_FINISH);
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      if (state == S_FINISH) queue_length <= 6'(count[qsel]);
    end
    op           <= op_next;
    qsel         <= qsel_next;
    wq           <= wq_next;
    hnd          <= hnd_next;
    prio         <= prio_next;
    cur          <= cur_next;
    prev         <= prev_next;
    newi         <= newi_next;
    prev_ent     <= prev_ent_next;
    has_prev     <= has_prev_next;
    k            <= k_next;
    status       <= status_next;
    out_handle   <= out_handle_next;
    out_priority <= out_priority_next;
    location     <= location_next;
  end

endmodule

### sv/pqt_checker.sv
`timescale 1ns / 1ps
`include "process_queue_table_macros.svh"
// ----------------------------------------------------------------------------
// pqt_checker
// Port-level checks on the process queue table.
// ----------------------------------------------------------------------------
module pqt_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] status,
  input logic [2:0] location,
  input logic [5:0] queue_length
);

  `PQT_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "busy not raised")
  `PQT_ASSERT_IMP(a_done_idle, clk, rst, done, !busy, "done while busy")
  `PQT_ASSERT_NEXT(a_start_no_done, clk, rst, start && !busy, !done, "done right after start")
  `PQT_ASSERT_IMP(a_len, clk, rst, done, queue_length <= 6'd32, "length out of range")
  `PQT_ASSERT_IMP(a_loc, clk, rst, done && location != 3'd0, status == 2'd0,
                  "location with error")

endmodule

bind process_queue_table pqt_checker u_pqt_checker (
  .clk, .rst, .start, .busy, .done, .status, .location, .queue_length
);
